@@ sv/two_class_priority_queue_with_undo_defines.svh @@
// Assertion macros for the two-class priority queue checker.
// Taken in by the checker file; depends on nothing else.
`ifndef TWO_CLASS_PRIORITY_QUEUE_WITH_UNDO_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_WITH_UNDO_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TCPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpq assertion failed");

`endif

@@ sv/tcpq_pkg.sv @@
// Shared types and codes for the two-class priority queue.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package tcpq_pkg;

   // Operation codes carried by an input word.
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SERVE = 2'd1,
      OP_PEEK  = 2'd2,
      OP_UNDO  = 2'd3
   } op_type;

   // Status codes carried by a result word.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the input word and launch the store reads
      logic commit;    // apply the operation and load the result register
   } cmd_type;

endpackage

`default_nettype wire

@@ sv/tcpq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tcpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/tcpq_ctrl.sv @@
// Controller for the two-class priority queue: sequences capture and commit
// and owns the result valid flag. Depends on tcpq_pkg.
`default_nettype none

module tcpq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tcpq_pkg::cmd_type      cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // The result register can take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A new word is taken only while no operation is in flight.
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   // State and registered output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/tcpq_datapath.sv @@
// Datapath for the two-class priority queue: pointers, counts, the three
// stores and the result register. Depends on tcpq_pkg and tcpq_ram.
`default_nettype none

module tcpq_datapath #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int HISTORY_DEPTH = 16,
   parameter int ID_WIDTH      = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tcpq_pkg::cmd_type cmd,
   input  wire logic [1:0]        req_operation,
   input  wire logic [15:0]       req_item_id,
   input  wire logic              req_urgent_class,
   input  wire logic [7:0]        req_server_number,
   output logic      [1:0]        rsp_status,
   output logic      [15:0]       rsp_result_id,
   output logic                   rsp_result_urgent,
   output logic      [7:0]        rsp_result_server
);

   localparam int QA = $clog2(QUEUE_DEPTH);
   localparam int QC = $clog2(QUEUE_DEPTH + 1);
   localparam int HA = $clog2(HISTORY_DEPTH);
   localparam int HC = $clog2(HISTORY_DEPTH + 1);
   localparam int RW = ID_WIDTH + 9;

   localparam logic [QA-1:0] Q_LAST = QA'(QUEUE_DEPTH - 1);
   localparam logic [QC-1:0] Q_FULL = QC'(QUEUE_DEPTH);
   localparam logic [HA-1:0] H_LAST = HA'(HISTORY_DEPTH - 1);
   localparam logic [HC-1:0] H_FULL = HC'(HISTORY_DEPTH);

   // Captured input word.
   tcpq_pkg::op_type    op_ff;
   logic [ID_WIDTH-1:0] id_ff;
   logic                cls_ff;
   logic [7:0]          srv_ff;
   logic [31:0]         id_wide;

   // Queue and history bookkeeping.
   logic [QA-1:0] u_head_ff, u_head_in, u_tail_ff, u_tail_in;
   logic [QC-1:0] u_count_ff, u_count_in;
   logic [QA-1:0] n_head_ff, n_head_in, n_tail_ff, n_tail_in;
   logic [QC-1:0] n_count_ff, n_count_in;
   logic [HA-1:0] h_top_ff, h_top_in, h_prev;
   logic [HC-1:0] h_count_ff, h_count_in;

   // Store ports.
   logic                u_we, n_we, h_we;
   logic [ID_WIDTH-1:0] q_wdata;
   logic [RW-1:0]       h_wdata;
   logic [ID_WIDTH-1:0] u_rd, n_rd;
   logic [RW-1:0]       h_rd;
   logic [ID_WIDTH-1:0] h_id;
   logic [7:0]          h_srv;
   logic                h_urg;

   // Result register.
   tcpq_pkg::status_type status_ff, status_in;
   logic [ID_WIDTH-1:0]  rid_ff, rid_in;
   logic                 rurg_ff, rurg_in;
   logic [7:0]           rsrv_ff, rsrv_in;
   logic [31:0]          rid_wide;

   function automatic logic [QA-1:0] q_inc(input logic [QA-1:0] ptr);
      q_inc = (ptr == Q_LAST) ? '0 : QA'(ptr + 1'b1);
   endfunction

   function automatic logic [HA-1:0] h_inc(input logic [HA-1:0] ptr);
      h_inc = (ptr == H_LAST) ? '0 : HA'(ptr + 1'b1);
   endfunction

   // Item IDs keep their low ID_WIDTH bits.
   assign id_wide = 32'(req_item_id);

   // Slot of the newest history record.
   assign h_prev = (h_top_ff == '0) ? H_LAST : HA'(h_top_ff - 1'b1);

   assign h_id  = h_rd[ID_WIDTH-1:0];
   assign h_srv = h_rd[ID_WIDTH+7:ID_WIDTH];
   assign h_urg = h_rd[RW-1];

   // Queue stores are written at the tail by add or undo.
   assign q_wdata = (op_ff == tcpq_pkg::OP_ADD) ? id_ff : h_id;

   tcpq_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_urgent_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (u_tail_ff),
      .wr_data (q_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (u_head_ff),
      .rd_data (u_rd)
   );

   tcpq_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_normal_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_tail_ff),
      .wr_data (q_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (n_head_ff),
      .rd_data (n_rd)
   );

   tcpq_ram #(.WIDTH(RW), .DEPTH(HISTORY_DEPTH)) u_history_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_top_ff),
      .wr_data (h_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (h_prev),
      .rd_data (h_rd)
   );

   // Operation execution on the captured word and the read data.
   always_comb begin
      u_head_in  = u_head_ff;
      u_tail_in  = u_tail_ff;
      u_count_in = u_count_ff;
      n_head_in  = n_head_ff;
      n_tail_in  = n_tail_ff;
      n_count_in = n_count_ff;
      h_top_in   = h_top_ff;
      h_count_in = h_count_ff;
      u_we       = 1'b0;
      n_we       = 1'b0;
      h_we       = 1'b0;
      h_wdata    = '0;
      status_in  = tcpq_pkg::STAT_OK;
      rid_in     = '0;
      rurg_in    = 1'b0;
      rsrv_in    = '0;
      unique case (op_ff)
         tcpq_pkg::OP_ADD: begin
            if (cls_ff) begin
               if (u_count_ff == Q_FULL) begin
                  status_in = tcpq_pkg::STAT_FULL;
               end else begin
                  u_we       = cmd.commit;
                  u_tail_in  = q_inc(u_tail_ff);
                  u_count_in = QC'(u_count_ff + 1'b1);
               end
            end else begin
               if (n_count_ff == Q_FULL) begin
                  status_in = tcpq_pkg::STAT_FULL;
               end else begin
                  n_we       = cmd.commit;
                  n_tail_in  = q_inc(n_tail_ff);
                  n_count_in = QC'(n_count_ff + 1'b1);
               end
            end
         end
         tcpq_pkg::OP_SERVE, tcpq_pkg::OP_PEEK: begin
            if (u_count_ff != '0) begin
               rid_in  = u_rd;
               rurg_in = 1'b1;
               if (op_ff == tcpq_pkg::OP_SERVE) begin
                  u_head_in  = q_inc(u_head_ff);
                  u_count_in = QC'(u_count_ff - 1'b1);
               end
            end else if (n_count_ff != '0) begin
               rid_in = n_rd;
               if (op_ff == tcpq_pkg::OP_SERVE) begin
                  n_head_in  = q_inc(n_head_ff);
                  n_count_in = QC'(n_count_ff - 1'b1);
               end
            end else begin
               status_in = tcpq_pkg::STAT_EMPTY;
            end
            // A serve records its item; a full history drops the oldest record.
            if (op_ff == tcpq_pkg::OP_SERVE && status_in == tcpq_pkg::STAT_OK) begin
               rsrv_in  = srv_ff;
               h_we     = cmd.commit;
               h_wdata  = {rurg_in, srv_ff, rid_in};
               h_top_in = h_inc(h_top_ff);
               if (h_count_ff != H_FULL) begin
                  h_count_in = HC'(h_count_ff + 1'b1);
               end
            end
         end
         tcpq_pkg::OP_UNDO: begin
            if (h_count_ff == '0) begin
               status_in = tcpq_pkg::STAT_EMPTY;
            end else if ((h_urg && u_count_ff == Q_FULL) ||
                         (!h_urg && n_count_ff == Q_FULL)) begin
               status_in = tcpq_pkg::STAT_FULL;
            end else begin
               if (h_urg) begin
                  u_we       = cmd.commit;
                  u_tail_in  = q_inc(u_tail_ff);
                  u_count_in = QC'(u_count_ff + 1'b1);
               end else begin
                  n_we       = cmd.commit;
                  n_tail_in  = q_inc(n_tail_ff);
                  n_count_in = QC'(n_count_ff + 1'b1);
               end
               h_top_in   = h_prev;
               h_count_in = HC'(h_count_ff - 1'b1);
               rid_in     = h_id;
               rurg_in    = h_urg;
               rsrv_in    = h_srv;
            end
         end
         default: begin
            status_in = tcpq_pkg::STAT_OK;
         end
      endcase
   end

   // Captured word and result payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= tcpq_pkg::op_type'(req_operation);
         id_ff  <= id_wide[ID_WIDTH-1:0];
         cls_ff <= req_urgent_class;
         srv_ff <= req_server_number;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         rid_ff    <= rid_in;
         rurg_ff   <= rurg_in;
         rsrv_ff   <= rsrv_in;
      end
   end

   // Pointers and counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         u_head_ff  <= '0;
         u_tail_ff  <= '0;
         u_count_ff <= '0;
         n_head_ff  <= '0;
         n_tail_ff  <= '0;
         n_count_ff <= '0;
         h_top_ff   <= '0;
         h_count_ff <= '0;
      end else if (cmd.commit) begin
         u_head_ff  <= u_head_in;
         u_tail_ff  <= u_tail_in;
         u_count_ff <= u_count_in;
         n_head_ff  <= n_head_in;
         n_tail_ff  <= n_tail_in;
         n_count_ff <= n_count_in;
         h_top_ff   <= h_top_in;
         h_count_ff <= h_count_in;
      end
   end

   assign rid_wide          = 32'(rid_ff);
   assign rsp_status        = status_ff;
   assign rsp_result_id     = rid_wide[15:0];
   assign rsp_result_urgent = rurg_ff;
   assign rsp_result_server = rsrv_ff;

endmodule

`default_nettype wire

@@ sv/two_class_priority_queue_with_undo.sv @@
// Two-class strict-priority queue with an undo history of served items.
// The result word is registered at the commit that follows the capture of the
// input word; the capture launches the registered read of the queue and history
// RAMs. A new input word is not taken until the current one is committed, and a
// stalled result word holds back the commit of the next one.
// Reset clears pointers, counts and valid flags; the RAMs are never cleared.
`default_nettype none

module two_class_priority_queue_with_undo #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int HISTORY_DEPTH = 16,
   parameter int ID_WIDTH      = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_item_id,
   input  wire logic        req_urgent_class,
   input  wire logic [7:0]  req_server_number,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [1:0]  rsp_status,
   output logic      [15:0] rsp_result_id,
   output logic             rsp_result_urgent,
   output logic      [7:0]  rsp_result_server
);

   tcpq_pkg::cmd_type cmd;

   // Sequencing of each word.
   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Queues, history and result register.
   tcpq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .ID_WIDTH      (ID_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_operation),
      .req_item_id       (req_item_id),
      .req_urgent_class  (req_urgent_class),
      .req_server_number (req_server_number),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_urgent (rsp_result_urgent),
      .rsp_result_server (rsp_result_server)
   );

endmodule

`default_nettype wire

@@ sv/tcpq_checker.sv @@
// Port-level checker for the two-class priority queue, bound to the top level.
// Depends on tcpq_pkg and the assertion macro header.
`default_nettype none

`include "two_class_priority_queue_with_undo_defines.svh"

module tcpq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_result_id,
   input wire logic        rsp_result_urgent,
   input wire logic [7:0]  rsp_result_server
);

   // A waiting result word stays offered.
   `TCPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Once a word is taken, no other is taken until it has been worked.
   `TCPQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // Status never carries the unused code.
   `TCPQ_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid,
      rsp_status == tcpq_pkg::STAT_OK || rsp_status == tcpq_pkg::STAT_EMPTY ||
      rsp_status == tcpq_pkg::STAT_FULL)

   // A refused or empty operation reports no item.
   `TCPQ_ASSERT_IMPLY(a_fail_zero, clock, reset,
      rsp_valid && rsp_status != tcpq_pkg::STAT_OK,
      rsp_result_id == 16'd0 && !rsp_result_urgent && rsp_result_server == 8'd0)

endmodule

bind two_class_priority_queue_with_undo tcpq_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_result_id     (rsp_result_id),
   .rsp_result_urgent (rsp_result_urgent),
   .rsp_result_server (rsp_result_server)
);

`default_nettype wire

@@ bench/two_class_priority_queue_with_undo_tb.sv @@
// Self-checking bench for the two-class priority queue with undo history.
// Needs tcpq_pkg and two_class_priority_queue_with_undo; a scoreboard class
// predicts each reply word and random valid/stall traffic drives both channels.
`default_nettype none

module two_class_priority_queue_with_undo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH   = 16;
   localparam int HIST_DEPTH   = 16;
   localparam int RANDOM_WORDS = 1530;
   localparam int CYCLE_LIMIT  = 120000;
   localparam int HOLD_CYCLES  = 300;

   // One reply word as the block should present it.
   typedef struct {
      tcpq_pkg::status_type status;
      logic [15:0]          item;
      logic                 urgent;
      logic [7:0]           server;
   } reply_word_type;

   // Scoreboard: mirrors both waiting lines and the served-item history, and
   // keeps the replies still owed by the block in arrival order.
   class served_item_ledger;
      logic [15:0]    line_ids [2][LINE_DEPTH];  // index 1 is the urgent line
      logic [3:0]     line_head [2];
      logic [3:0]     line_tail [2];
      logic [4:0]     line_count [2];
      logic [15:0]    hist_item [HIST_DEPTH];
      logic           hist_urgent [HIST_DEPTH];
      logic [7:0]     hist_server [HIST_DEPTH];
      logic [3:0]     hist_top;
      logic [4:0]     hist_count;
      reply_word_type owed_replies [$];
      int             errors;

      function new();
         for (int c = 0; c < 2; c++) begin
            line_head[c]  = '0;
            line_tail[c]  = '0;
            line_count[c] = '0;
         end
         hist_top   = '0;
         hist_count = '0;
         errors     = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // Apply one accepted request word and queue the reply it must produce.
      function void note_request(tcpq_pkg::op_type op, logic [15:0] id, logic cls,
                                 logic [7:0] srv);
         reply_word_type r;
         int             sel;
         logic [3:0]     slot;
         logic           rc;
         r = '{status: tcpq_pkg::STAT_OK, item: '0, urgent: 1'b0, server: '0};
         case (op)
            tcpq_pkg::OP_ADD: begin
               if (line_count[cls] == LINE_DEPTH) begin
                  r.status = tcpq_pkg::STAT_FULL;
               end else begin
                  line_ids[cls][line_tail[cls]] = id;
                  line_tail[cls]  = line_tail[cls] + 4'd1;
                  line_count[cls] = line_count[cls] + 5'd1;
               end
            end
            tcpq_pkg::OP_SERVE, tcpq_pkg::OP_PEEK: begin
               // The urgent line always goes first.
               sel = (line_count[1] != 0) ? 1 : ((line_count[0] != 0) ? 0 : -1);
               if (sel < 0) begin
                  r.status = tcpq_pkg::STAT_EMPTY;
               end else begin
                  r.item   = line_ids[sel][line_head[sel]];
                  r.urgent = (sel == 1);
                  if (op == tcpq_pkg::OP_SERVE) begin
                     line_head[sel]  = line_head[sel] + 4'd1;
                     line_count[sel] = line_count[sel] - 5'd1;
                     r.server = srv;
                     // A full history drops its oldest record.
                     hist_item[hist_top]   = r.item;
                     hist_urgent[hist_top] = r.urgent;
                     hist_server[hist_top] = srv;
                     hist_top = hist_top + 4'd1;
                     if (hist_count < HIST_DEPTH)
                        hist_count = hist_count + 5'd1;
                  end
               end
            end
            default: begin
               // Undo: requeue the newest record unless its line is full.
               if (hist_count == 0) begin
                  r.status = tcpq_pkg::STAT_EMPTY;
               end else begin
                  slot = hist_top - 4'd1;
                  rc   = hist_urgent[slot];
                  if (line_count[rc] == LINE_DEPTH) begin
                     r.status = tcpq_pkg::STAT_FULL;
                  end else begin
                     line_ids[rc][line_tail[rc]] = hist_item[slot];
                     line_tail[rc]  = line_tail[rc] + 4'd1;
                     line_count[rc] = line_count[rc] + 5'd1;
                     hist_top   = slot;
                     hist_count = hist_count - 5'd1;
                     r.item   = hist_item[slot];
                     r.urgent = rc;
                     r.server = hist_server[slot];
                  end
               end
            end
         endcase
         owed_replies.push_back(r);
      endfunction

      // Compare one accepted reply word with the oldest owed reply.
      task check_reply(logic [1:0] st, logic [15:0] id, logic urg, logic [7:0] srv);
         reply_word_type e;
         if (owed_replies.size() == 0) begin
            report($sformatf("reply with none owed: status=%0d id=%h", st, id));
         end else begin
            e = owed_replies.pop_front();
            if (st !== e.status)
               report($sformatf("status %0d, wanted %0d", st, e.status));
            if (id !== e.item)
               report($sformatf("result_id %h, wanted %h", id, e.item));
            if (urg !== e.urgent)
               report($sformatf("result_urgent %b, wanted %b", urg, e.urgent));
            if (srv !== e.server)
               report($sformatf("result_server %0d, wanted %0d", srv, e.server));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = tcpq_pkg::OP_ADD;
   logic [15:0] req_item_id = '0;
   logic        req_urgent_class = 1'b0;
   logic [7:0]  req_server_number = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_result_id;
   logic        rsp_result_urgent;
   logic [7:0]  rsp_result_server;

   served_item_ledger ledger = new();
   bit  quiet     = 1'b0;   // no idling on either side while set
   bit  hold_go   = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   int  cycle_count = 0;

   two_class_priority_queue_with_undo i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_item_id       (req_item_id),
      .req_urgent_class  (req_urgent_class),
      .req_server_number (req_server_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_urgent (rsp_result_urgent),
      .rsp_result_server (rsp_result_server)
   );

   always #2 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 7);
      end
   end

   // Check every reply word taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_reply(rsp_status, rsp_result_id, rsp_result_urgent,
                            rsp_result_server);
   end

   // Offer one request word and hold it until the block takes it.
   task send_word(tcpq_pkg::op_type op, logic [15:0] id, logic cls, logic [7:0] srv);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_item_id       <= id;
      req_urgent_class  <= cls;
      req_server_number <= srv;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      ledger.note_request(op, id, cls, srv);
   endtask

   // Random item ID with the extremes weighted in.
   function automatic logic [15:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'h0000;
      if (r < 10) return 16'hFFFF;
      return 16'($urandom_range(16'hFFFF));
   endfunction

   initial begin
      int               mode;
      int               seg_left;
      logic             seg_class;
      int               r;
      tcpq_pkg::op_type op;
      logic             cls;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty cases, extreme fields, priority order and undo.
      send_word(tcpq_pkg::OP_SERVE, 16'h1234, 1'b1, 8'd5);
      send_word(tcpq_pkg::OP_PEEK,  16'hFFFF, 1'b0, 8'd9);
      send_word(tcpq_pkg::OP_UNDO,  16'h0000, 1'b1, 8'd7);
      send_word(tcpq_pkg::OP_ADD,   16'hFFFF, 1'b0, 8'd255);
      send_word(tcpq_pkg::OP_ADD,   16'h0000, 1'b1, 8'd0);
      send_word(tcpq_pkg::OP_ADD,   16'h5A5A, 1'b0, 8'd1);
      send_word(tcpq_pkg::OP_ADD,   16'hA5A5, 1'b1, 8'd2);
      send_word(tcpq_pkg::OP_PEEK,  16'h0000, 1'b0, 8'd3);
      send_word(tcpq_pkg::OP_SERVE, 16'hFFFF, 1'b0, 8'd255);
      send_word(tcpq_pkg::OP_SERVE, 16'h0000, 1'b1, 8'd0);
      send_word(tcpq_pkg::OP_PEEK,  16'h0000, 1'b1, 8'd77);
      send_word(tcpq_pkg::OP_UNDO,  16'hFFFF, 1'b0, 8'd100);
      send_word(tcpq_pkg::OP_UNDO,  16'h0000, 1'b0, 8'd1);
      send_word(tcpq_pkg::OP_UNDO,  16'h0000, 1'b0, 8'd1);
      send_word(tcpq_pkg::OP_SERVE, 16'h0000, 1'b0, 8'd1);
      send_word(tcpq_pkg::OP_SERVE, 16'h0000, 1'b0, 8'd128);
      send_word(tcpq_pkg::OP_SERVE, 16'h0000, 1'b0, 8'd64);
      send_word(tcpq_pkg::OP_SERVE, 16'h0000, 1'b0, 8'd32);
      send_word(tcpq_pkg::OP_SERVE, 16'h0000, 1'b0, 8'd16);
      send_word(tcpq_pkg::OP_PEEK,  16'h0000, 1'b0, 8'd0);

      // Random: segments that fill a line, drain it, undo into it, or mix.
      seg_left = 0;
      mode = 0;
      seg_class = 1'b0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 250) hold_go = 1'b1;
         quiet = (n >= 600 && n < 900);
         if (seg_left == 0) begin
            seg_left  = $urandom_range(50, 10);
            mode      = $urandom_range(3);
            seg_class = 1'($urandom_range(1));
         end
         seg_left--;
         r = $urandom_range(99);
         cls = ($urandom_range(99) < 80) ? seg_class : 1'($urandom_range(1));
         case (mode)
            0: op = (r < 85) ? tcpq_pkg::OP_ADD :
                    tcpq_pkg::op_type'($urandom_range(3, 1));
            1: op = (r < 75) ? tcpq_pkg::OP_SERVE : (r < 85) ? tcpq_pkg::OP_PEEK :
                    (r < 93) ? tcpq_pkg::OP_ADD : tcpq_pkg::OP_UNDO;
            2: op = (r < 45) ? tcpq_pkg::OP_UNDO : (r < 90) ? tcpq_pkg::OP_ADD :
                    tcpq_pkg::op_type'($urandom_range(2, 1));
            default: op = tcpq_pkg::op_type'($urandom_range(3));
         endcase
         send_word(op, pick_id(), cls, 8'($urandom_range(255)));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the owed replies, then let the pipeline settle.
      while (ledger.owed_replies.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
